// File: rtl/core/plt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_pkg: shared types and constants of the packet loss tracker
// Item layouts, operation and result codes, and parameter defaults.
// ----------------------------------------------------------------------------
package plt_pkg;

    // Field widths, fixed by the item layout
    localparam int MODE_W  = 2;
    localparam int SEQ_W   = 12;
    localparam int SIZE_W  = 23;
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 12;
    localparam int COUNT_W = 7;

    // Parameter defaults
    localparam int DEF_MAX_PACKETS  = 4096;
    localparam int DEF_PACKET_BYTES = 1450;
    localparam int DEF_LOST_CAP     = 64;

    // Input operation codes
    localparam logic [MODE_W-1:0] MODE_PREPARE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DATA    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STOP    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MISS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SEQ_W-1:0]  seq_number;
        logic [SIZE_W-1:0] total_size;
    } plt_in_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] lost_index;
        logic [COUNT_W-1:0] lost_count;
        logic               last;
    } plt_out_t;

endpackage

// File: rtl/core/plt_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_chan_if: valid/ready channel
// Carries one item per handshake; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface plt_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/plt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_ram: generic single-port RAM
// One access per cycle, write or read; read data registered.
// ----------------------------------------------------------------------------
module plt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/core/plt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_div: divider by a constant
// Reciprocal multiply: the quotient is the scaled product shifted right,
// exact over the full dividend range; the result is ready in the cycle after start.
// ----------------------------------------------------------------------------
module plt_div
    import plt_pkg::*;
#(
    parameter int DIVISOR = DEF_PACKET_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SIZE_W-1:0] dividend,
    output logic              done,
    output logic [SIZE_W-1:0] quotient
);
    // A shift of dividend width plus divisor width keeps the rounding
    // error below one over the whole dividend range
    localparam int SHIFT   = SIZE_W + $clog2(DIVISOR);
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + longint'(DIVISOR) - 64'd1) / longint'(DIVISOR);
    localparam int RECIP_W = SIZE_W + 2;
    localparam int PROD_W  = SIZE_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              done_reg, done_next;

    always_comb
    begin
        prod_next = prod_reg;
        done_next = start;
        if (start)
        begin
            prod_next = PROD_W'(dividend) * PROD_W'(RECIP_C);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign done     = done_reg;
    assign quotient = SIZE_W'(prod_reg >> SHIFT);
endmodule

// File: rtl/core/packet_loss_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_loss_tracker_unit: receive bitmap and missing-packet list
// Marks arrived packets in a presence map and lists the missing ones.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per handshake: mode, seq_number, total_size.
//   rsp carries result items: kind, lost_index, lost_count, last; the final
//   result of each request has last set. req.ready is high only while the
//   sequencer is idle; one request is worked on at a time.
//   Data and stop items are taken in the idle state and give no result.
//   Prepare (not yet prepared): the divider turns the total size into the
//   packet count, then the map is cleared entry by entry up to that count,
//   then the acknowledge is loaded into the output register. Prepare while
//   prepared: acknowledge only.
//   Query: each scanned index takes a map read state, then a check state,
//   since the single map port is read once per index; the scan stops at the
//   packet count or at the cap, and a final state gives the last result.
//   A result waits in the output register while rsp stalls; the scan holds
//   once it has a result to hand over and the register is still full.
//   Reset leaves the block unprepared with a zero packet count; the map is
//   not cleared by reset, only by the next prepare, before any read of it.
// ----------------------------------------------------------------------------
module packet_loss_tracker_unit
    import plt_pkg::*;
#(
    parameter int MAX_PACKETS  = DEF_MAX_PACKETS,
    parameter int PACKET_BYTES = DEF_PACKET_BYTES,
    parameter int LOST_CAP     = DEF_LOST_CAP
) (
    input  logic clk,
    input  logic rst_n,
    plt_chan_if.sink   req,
    plt_chan_if.source rsp
);
    localparam int IDX_W = $clog2(MAX_PACKETS);
    localparam int CNT_W = $clog2(MAX_PACKETS + 1);
    localparam int NUM_W = $clog2(LOST_CAP + 1);
    localparam int CMP_W = (CNT_W > SEQ_W) ? CNT_W : SEQ_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_CLR  = 3'd2;
    localparam logic [2:0] S_ACK  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_CHK  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic             prepared_reg, prepared_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    plt_out_t         out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic             in_fire;
    logic             out_free;
    logic             div_start;
    logic             div_done;
    logic [SIZE_W-1:0] quot;
    logic [CNT_W-1:0] quot_sat;
    logic             ram_we;
    logic [IDX_W-1:0] ram_addr;
    logic             ram_rdata;
    logic             idx_at_end;
    logic [NUM_W-1:0] num_inc;

    assign in_fire   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    // Saturate the packet count at the map size
    assign quot_sat = (quot > SIZE_W'(MAX_PACKETS)) ? CNT_W'(MAX_PACKETS) : CNT_W'(quot);

    assign idx_at_end = (CNT_W'(idx_reg) + CNT_W'(1)) == total_reg;
    assign num_inc    = num_reg + NUM_W'(1);

    plt_div #(
        .DIVISOR (PACKET_BYTES)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (req.payload.total_size),
        .done     (div_done),
        .quotient (quot)
    );

    plt_ram #(
        .WIDTH (1),
        .DEPTH (MAX_PACKETS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (state_reg == S_IDLE),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        prepared_next   = prepared_reg;
        total_next      = total_reg;
        idx_next        = idx_reg;
        num_next        = num_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        div_start       = 1'b0;
        ram_we          = 1'b0;
        ram_addr        = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                // Data items write a one at the sequence number in place
                ram_addr = IDX_W'(req.payload.seq_number);
                if (in_fire)
                begin
                    case (req.payload.mode)
                        MODE_PREPARE:
                        begin
                            if (prepared_reg)
                            begin
                                state_next = S_ACK;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        MODE_DATA:
                        begin
                            ram_we = prepared_reg &&
                                (CMP_W'(req.payload.seq_number) < CMP_W'(total_reg));
                        end
                        MODE_STOP:
                        begin
                            prepared_next = 1'b0;
                        end
                        MODE_QUERY:
                        begin
                            idx_next        = '0;
                            num_next        = '0;
                            pend_valid_next = 1'b0;
                            if (prepared_reg)
                            begin
                                state_next = (total_reg == '0) ? S_FIN : S_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    total_next    = quot_sat;
                    prepared_next = 1'b1;
                    idx_next      = '0;
                    state_next    = (quot_sat == '0) ? S_ACK : S_CLR;
                end
            end
            S_CLR:
            begin
                // Clear only the entries below the count; the rest stay unread
                ram_we = 1'b1;
                if (idx_at_end)
                begin
                    state_next = S_ACK;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_ACK:
            begin
                if (out_free)
                begin
                    out_next       = '{KIND_ACK, '0, '0, 1'b1};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                // Hold one found index back until the next one decides its last flag
                if (!(!ram_rdata && pend_valid_reg && !out_free))
                begin
                    if (!ram_rdata)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next = '{KIND_MISS, INDEX_W'(pend_idx_reg),
                                         COUNT_W'(num_reg), 1'b0};
                            out_valid_next = 1'b1;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = idx_reg;
                        num_next        = num_inc;
                    end
                    if (idx_at_end || (!ram_rdata && num_inc == NUM_W'(LOST_CAP)))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next = '{KIND_MISS, INDEX_W'(pend_idx_reg),
                                     COUNT_W'(num_reg), 1'b1};
                    end
                    else
                    begin
                        out_next = '{KIND_NONE, '0, '0, 1'b1};
                    end
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prepared_reg   <= 1'b0;
            total_reg      <= '0;
            idx_reg        <= '0;
            num_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prepared_reg   <= prepared_next;
            total_reg      <= total_next;
            idx_reg        <= idx_next;
            num_reg        <= num_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        out_reg      <= out_next;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

`ifndef ASSERT_OFF
    // The reported count never passes the cap
    a_num_cap: assert property (@(posedge clk) disable iff (!rst_n)
        num_reg <= NUM_W'(LOST_CAP))
        else $error("lost count beyond cap");

    // A held-back index always has a nonzero ordinal
    a_pend_num: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> num_reg != '0)
        else $error("pending index without count");

    // Scan and clear stay inside the packet count
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD || state_reg == S_CHK || state_reg == S_CLR)
            |-> CNT_W'(idx_reg) < total_reg)
        else $error("map index beyond packet count");

    // A finished division leads to clearing or the acknowledge
    a_div_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_done) |=> (state_reg == S_CLR || state_reg == S_ACK))
        else $error("divider result not taken");
`endif
endmodule
